>>> hw/rtl/cmt_pkg.sv
`default_nettype none

package cmt_pkg;

    // Sizes of the block; the register map fixes four tokens of eight characters.
    localparam int NUM_TOKENS    = 4;
    localparam int MAX_TOKEN_LEN = 8;
    localparam int TOK_W         = 2;   // token index
    localparam int TOK_CNT_W     = 3;   // token counter, holds NUM_TOKENS itself
    localparam int POS_W         = 3;   // match position below the token length
    localparam int LEN_W         = 4;   // token length 0..8
    localparam int CHAR_W        = 8;
    localparam int CODE_W        = 8;
    localparam int REG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int TICK_W        = 32;
    localparam int CAP_W         = 9;

    // Commands of an input item.
    localparam logic [1:0] CMD_ARM   = 2'd0;
    localparam logic [1:0] CMD_CHAR  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_CLOSE = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_WAITING   = 3'd0;
    localparam logic [2:0] ST_MATCHED   = 3'd1;
    localparam logic [2:0] ST_TIMEOUT   = 3'd2;
    localparam logic [2:0] ST_ERROR     = 3'd3;
    localparam logic [2:0] ST_NOT_ARMED = 3'd4;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_0     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_1     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_2     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_3     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LENGTHS       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TOKEN_CODES   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT       = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CAPTURE_LIMIT = 3'd7;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd1000;

    typedef struct packed {
        logic [1:0]        command;
        logic [CHAR_W-1:0] char_value;
    } item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [CODE_W-1:0] token_code;
        logic [TOK_W-1:0]  token_index;
        logic              capture_valid;
        logic [CHAR_W-1:0] captured_char;
    } result_t;

    // Controller to datapath.
    typedef struct packed {
        logic take_item;
        logic exec;
        logic load;
        logic scan;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic walk;
        logic tok_end;
        logic matched;
        logic tok_next;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/cmt_ctrl.sv
`default_nettype none

module cmt_ctrl
    import cmt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    output logic           result_valid,
    input  wire logic      result_ready,
    output ctrl_cmd_t      cmd,
    input  wire dp_stat_t  stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   out_free;

    always_comb
    begin
        out_free      = !result_valid_reg || result_ready;
        cmd           = '0;
        cmd.take_item = (state_reg == S_IDLE) && item_valid;
        cmd.exec      = (state_reg == S_EXEC);
        cmd.load      = (state_reg == S_LOAD);
        cmd.scan      = (state_reg == S_SCAN);
        cmd.load_out  = (state_reg == S_FINISH) && out_free;

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = stat.walk ? S_LOAD : S_FINISH;
            end
            S_LOAD:
            begin
                state_next = stat.tok_end ? S_FINISH : S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.matched)
                    state_next = S_FINISH;
                else if (stat.tok_next)
                    state_next = S_LOAD;
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/cmt_dp.sv
`default_nettype none

module cmt_dp
    import cmt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire item_t                 item,
    input  wire ctrl_cmd_t             cmd,
    output dp_stat_t                   stat,
    output result_t                    result
);

    function automatic logic [CHAR_W-1:0] chr_at(input logic [CFG_DATA_W-1:0] p,
                                                  input logic [POS_W-1:0] i);
        return p[{i, 3'b000} +: CHAR_W];
    endfunction

    // Configuration registers.
    logic [CFG_DATA_W-1:0]       pattern_reg [NUM_TOKENS];
    logic [NUM_TOKENS*LEN_W-1:0] lengths_reg;
    logic [NUM_TOKENS*CODE_W-1:0] codes_reg;
    logic [TICK_W-1:0]           timeout_reg;
    logic [CAP_W-1:0]            climit_reg;

    // Matcher state.
    logic [POS_W-1:0]     pos_reg [NUM_TOKENS];
    logic [POS_W-1:0]     pos_next [NUM_TOKENS];
    logic                 armed_reg, armed_next;
    logic [TICK_W-1:0]    elapsed_reg, elapsed_next;
    logic [CAP_W-1:0]     saved_reg, saved_next;

    // Working registers of the token walk.
    item_t                item_reg, item_next;
    logic [TOK_CNT_W-1:0] tok_reg, tok_next;
    logic [POS_W-1:0]     cur_pos_reg, cur_pos_next;
    logic [POS_W-1:0]     k_reg, k_next;
    result_t              res_reg, res_next;
    result_t              out_reg, out_next;

    logic [TOK_W-1:0]      tok_sel;
    logic [CFG_DATA_W-1:0] pat_cur;
    logic [LEN_W-1:0]      len_raw, len_cur;
    logic                  stale;
    logic                  same, hit, complete;
    logic [TICK_W-1:0]     elapsed_inc;

    always_comb
    begin
        tok_sel = tok_reg[TOK_W-1:0];
        pat_cur = pattern_reg[tok_sel];
        len_raw = lengths_reg[{tok_sel, 2'b00} +: LEN_W];
        len_cur = (len_raw > LEN_W'(MAX_TOKEN_LEN)) ? LEN_W'(MAX_TOKEN_LEN) : len_raw;
        stale   = {1'b0, pos_reg[tok_sel]} >= len_cur;

        // Candidate border of length k: prefix of k characters equals the last k matched.
        same = 1'b1;
        for (int j = 0; j < MAX_TOKEN_LEN; j++)
        begin
            if (POS_W'(j) < k_reg)
            begin
                if (chr_at(pat_cur, POS_W'(j)) !=
                    chr_at(pat_cur, POS_W'(cur_pos_reg - k_reg + POS_W'(j))))
                    same = 1'b0;
            end
        end
        hit      = same && (chr_at(pat_cur, k_reg) == item_reg.char_value);
        complete = (LEN_W'({1'b0, k_reg} + LEN_W'(1)) == len_cur);

        stat.walk     = (item_reg.command == CMD_CHAR) && armed_reg;
        stat.tok_end  = (tok_reg == TOK_CNT_W'(NUM_TOKENS)) || (len_cur == '0);
        stat.matched  = hit && complete;
        stat.tok_next = hit ? !complete : (k_reg == '0);

        elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + TICK_W'(1);

        item_next    = cmd.take_item ? item : item_reg;
        pos_next     = pos_reg;
        armed_next   = armed_reg;
        elapsed_next = elapsed_reg;
        saved_next   = saved_reg;
        tok_next     = tok_reg;
        cur_pos_next = cur_pos_reg;
        k_next       = k_reg;
        res_next     = res_reg;
        out_next     = cmd.load_out ? res_reg : out_reg;

        if (cmd.exec)
        begin
            res_next = '0;
            tok_next = '0;
            if (item_reg.command == CMD_ARM)
            begin
                for (int t = 0; t < NUM_TOKENS; t++)
                    pos_next[t] = '0;
                elapsed_next = '0;
                saved_next   = '0;
                armed_next   = 1'b1;
            end
            else if (!armed_reg)
            begin
                res_next.status = ST_NOT_ARMED;
            end
            else
            begin
                case (item_reg.command)
                    CMD_TICK:
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc > timeout_reg)
                        begin
                            armed_next      = 1'b0;
                            res_next.status = ST_TIMEOUT;
                        end
                    end
                    CMD_CLOSE:
                    begin
                        armed_next      = 1'b0;
                        res_next.status = ST_ERROR;
                    end
                    default:
                    begin
                        if (({1'b0, saved_reg} + (CAP_W + 1)'(2)) < {1'b0, climit_reg})
                        begin
                            saved_next             = saved_reg + CAP_W'(1);
                            res_next.capture_valid = 1'b1;
                            res_next.captured_char = item_reg.char_value;
                        end
                    end
                endcase
            end
        end

        if (cmd.load)
        begin
            cur_pos_next = stale ? '0 : pos_reg[tok_sel];
            k_next       = stale ? '0 : pos_reg[tok_sel];
        end

        if (cmd.scan)
        begin
            if (hit && complete)
            begin
                armed_next           = 1'b0;
                res_next.status      = ST_MATCHED;
                res_next.token_code  = codes_reg[{tok_sel, 3'b000} +: CODE_W];
                res_next.token_index = tok_sel;
            end
            else if (hit)
            begin
                pos_next[tok_sel] = k_reg + POS_W'(1);
                tok_next          = tok_reg + TOK_CNT_W'(1);
            end
            else if (k_reg == '0)
            begin
                pos_next[tok_sel] = '0;
                tok_next          = tok_reg + TOK_CNT_W'(1);
            end
            else
            begin
                k_next = k_reg - POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TOKENS; t++)
            begin
                pattern_reg[t] <= '0;
                pos_reg[t]     <= '0;
            end
            lengths_reg <= '0;
            codes_reg   <= '0;
            timeout_reg <= TIMEOUT_RESET;
            climit_reg  <= '0;
            armed_reg   <= 1'b0;
            elapsed_reg <= '0;
            saved_reg   <= '0;
            tok_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index) inside
                    REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3:
                        pattern_reg[cfg_index[TOK_W-1:0]] <= cfg_data;
                    REG_LENGTHS:
                        lengths_reg <= cfg_data[NUM_TOKENS*LEN_W-1:0];
                    REG_TOKEN_CODES:
                        codes_reg <= cfg_data[NUM_TOKENS*CODE_W-1:0];
                    REG_TIMEOUT:
                        timeout_reg <= cfg_data[TICK_W-1:0];
                    REG_CAPTURE_LIMIT:
                        climit_reg <= cfg_data[CAP_W-1:0];
                    default:
                        climit_reg <= climit_reg;
                endcase
            end
            pos_reg     <= pos_next;
            armed_reg   <= armed_next;
            elapsed_reg <= elapsed_next;
            saved_reg   <= saved_next;
            tok_reg     <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        cur_pos_reg <= cur_pos_next;
        k_reg       <= k_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assign result = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/multi_token_expect_matcher.sv
// Arm, tick, close and a character while disarmed pass through the execute step only;
// an armed character then walks the tokens tried, each with one load step and 1 to 8
// border steps, and the walk ends as soon as a token completes.
// One item at a time: the next is taken in the cycle after the result is loaded.
// Reset (rst_n, asynchronous, active low): block disarmed, timeout limit 1000, other config
// registers, counters and match positions zero, no result pending; the output is not reset.
`default_nettype none

module multi_token_expect_matcher
    import cmt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire item_t                 item,

    output logic                       result_valid,
    input  wire logic                  result_ready,
    output result_t                    result
);

    // The controller sequences each item: an execute step that handles arm, tick,
    // close and the capture decision, then for an armed character a walk over the tokens
    // in list order. For each token one step loads its match position and then one
    // step per candidate border length tries the longest border first.
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Configuration transfers are always taken; the user must send them only while idle (not enforced).
    assign cfg_ready = 1'b1;

    cmt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .stat         (stat)
    );

    // The datapath holds the registers, the matcher state and the output register,
    // so a finished result can wait while the next item is accepted.
    cmt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

`default_nettype wire
